FILE: hdl/jdp_pkg.sv
// ----------------------------------------------------------------------------
// jdp_pkg
// Shared sizes, operation codes and result codes of the job dispatcher.
// ----------------------------------------------------------------------------
package jdp_pkg;

   // Sizes
   localparam int NUM_WORKERS = 16;
   localparam int QUEUE_DEPTH = 32;
   localparam int TAG_BITS    = 16;

   localparam int WKR_BITS = 4;   // worker id field
   localparam int CNT_BITS = 5;   // registered worker count, 0..NUM_WORKERS
   localparam int PTR_BITS = 5;   // queue head / tail
   localparam int QCT_BITS = 6;   // queued job count, 0..QUEUE_DEPTH
   localparam int POS_BITS = 5;   // queue position field

   // Event kinds on the request channel
   typedef enum logic [1:0] {
      OP_JOB      = 2'd0,
      OP_REGISTER = 2'd1,
      OP_READY    = 2'd2,
      OP_UNUSED   = 2'd3
   } op_type;

   // Result kinds on the response channel
   typedef enum logic [2:0] {
      ACT_DISPATCHED     = 3'd0,
      ACT_QUEUED         = 3'd1,
      ACT_FULL           = 3'd2,
      ACT_REG_IDLE       = 3'd3,
      ACT_REG_DISPATCH   = 3'd4,
      ACT_READY          = 3'd5,
      ACT_READY_DISPATCH = 3'd6,
      ACT_REJECT         = 3'd7
   } action_type;

endpackage

FILE: hdl/job_dispatcher_ready_pool_fifo_unit.sv
// ----------------------------------------------------------------------------
// job_dispatcher_ready_pool_fifo_unit
// Hands jobs to the lowest ready worker, or queues them in a circular FIFO
// held in a synchronous RAM until a worker registers or reports ready.
// ----------------------------------------------------------------------------
//  channel | direction | tuser                | tdata
//  req_    | in        | op [1:0]             | request_tag, worker_id
//  rsp_    | out       | action [2:0]         | assigned_worker, job_tag,
//          |           |                      | queue_position
//
//  An event that takes a queued job (registration or ready report with jobs
//  waiting) goes on to ST_POP for the registered read of the job RAM at the
//  queue head; no event is taken in ST_POP.
//  A result waits in an output register; the next event is taken while it
//  is being transferred. Synchronous active-high reset clears the pool,
//  the counts and the pointers; the job RAM is not cleared.
// ----------------------------------------------------------------------------
module job_dispatcher_ready_pool_fifo_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [15:0] request_tag, [19:16] worker_id
   input  logic [1:0]  req_tuser,   // [1:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [3:0] assigned_worker, [19:4] job_tag,
                                    // [24:20] queue_position
   output logic [2:0]  rsp_tuser    // [2:0] action
);
   import jdp_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_POP  = 2'b10
   } state_type;

   // Request fields
   logic [TAG_BITS-1:0] req_tag;
   logic [WKR_BITS-1:0] req_wid;
   op_type              req_op;

   assign req_tag = req_tdata[TAG_BITS-1:0];
   assign req_wid = req_tdata[TAG_BITS+WKR_BITS-1:TAG_BITS];
   assign req_op  = op_type'(req_tuser);

   // State registers
   state_type              state_ff, state_in;
   logic [NUM_WORKERS-1:0] ready_mask_ff, ready_mask_in;
   logic [CNT_BITS-1:0]    reg_count_ff, reg_count_in;
   logic [PTR_BITS-1:0]    head_ff, head_in;
   logic [PTR_BITS-1:0]    tail_ff, tail_in;
   logic [QCT_BITS-1:0]    q_count_ff, q_count_in;

   // Held result of an event waiting on the RAM read
   action_type          hold_act_ff, hold_act_in;
   logic [WKR_BITS-1:0] hold_wkr_ff, hold_wkr_in;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   action_type          rsp_act_ff, rsp_act_in;
   logic [WKR_BITS-1:0] rsp_wkr_ff, rsp_wkr_in;
   logic [TAG_BITS-1:0] rsp_tag_ff, rsp_tag_in;
   logic [POS_BITS-1:0] rsp_pos_ff, rsp_pos_in;

   // Job RAM
   logic [TAG_BITS-1:0] job_mem [QUEUE_DEPTH];
   logic [TAG_BITS-1:0] rd_data_ff;
   logic                mem_we;

   logic                req_accept;
   logic                pop_need;
   logic                any_ready;
   logic [WKR_BITS-1:0] low_ready;

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;
   assign any_ready  = |ready_mask_ff;

   // Lowest-numbered ready worker
   always_comb begin
      low_ready = '0;
      for (int i = NUM_WORKERS - 1; i >= 0; i--) begin
         if (ready_mask_ff[i]) begin
            low_ready = WKR_BITS'(i);
         end
      end
   end

   // Event decode and next state
   always_comb begin
      state_in      = state_ff;
      ready_mask_in = ready_mask_ff;
      reg_count_in  = reg_count_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      q_count_in    = q_count_ff;
      hold_act_in   = hold_act_ff;
      hold_wkr_in   = hold_wkr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_act_in    = rsp_act_ff;
      rsp_wkr_in    = rsp_wkr_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_pos_in    = rsp_pos_ff;
      mem_we        = 1'b0;
      pop_need      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               rsp_valid_in = 1'b1;
               rsp_act_in   = ACT_REJECT;
               rsp_wkr_in   = '0;
               rsp_tag_in   = '0;
               rsp_pos_in   = '0;
               case (req_op)
                  OP_JOB: begin
                     rsp_tag_in = req_tag;
                     if (any_ready) begin
                        ready_mask_in[low_ready] = 1'b0;
                        rsp_act_in = ACT_DISPATCHED;
                        rsp_wkr_in = low_ready;
                     end else if (q_count_ff >= QCT_BITS'(QUEUE_DEPTH)) begin
                        rsp_act_in = ACT_FULL;
                     end else begin
                        mem_we     = 1'b1;
                        tail_in    = (tail_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ?
                                     '0 : tail_ff + 1'b1;
                        q_count_in = q_count_ff + 1'b1;
                        rsp_act_in = ACT_QUEUED;
                        rsp_pos_in = q_count_ff[POS_BITS-1:0];
                     end
                  end
                  OP_REGISTER: begin
                     if (reg_count_ff < CNT_BITS'(NUM_WORKERS)) begin
                        reg_count_in = reg_count_ff + 1'b1;
                        if (q_count_ff != '0) begin
                           pop_need    = 1'b1;
                           hold_act_in = ACT_REG_DISPATCH;
                           hold_wkr_in = reg_count_ff[WKR_BITS-1:0];
                        end else begin
                           ready_mask_in[reg_count_ff[WKR_BITS-1:0]] = 1'b1;
                           rsp_act_in = ACT_REG_IDLE;
                           rsp_wkr_in = reg_count_ff[WKR_BITS-1:0];
                        end
                     end
                  end
                  OP_READY: begin
                     if ({1'b0, req_wid} < reg_count_ff) begin
                        if (q_count_ff != '0) begin
                           pop_need    = 1'b1;
                           hold_act_in = ACT_READY_DISPATCH;
                           hold_wkr_in = req_wid;
                        end else begin
                           ready_mask_in[req_wid] = 1'b1;
                           rsp_act_in = ACT_READY;
                           rsp_wkr_in = req_wid;
                        end
                     end
                  end
                  default: begin
                     rsp_act_in = ACT_REJECT;
                  end
               endcase

               // Popping: result waits in hold_act/hold_wkr for the registered RAM read
               if (pop_need) begin
                  rsp_valid_in = 1'b0;
                  head_in      = (head_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ?
                                 '0 : head_ff + 1'b1;
                  q_count_in   = q_count_ff - 1'b1;
                  state_in     = ST_POP;
               end
            end
         end
         ST_POP: begin
            // output register is empty here: it was free at acceptance
            rsp_valid_in = 1'b1;
            rsp_act_in   = hold_act_ff;
            rsp_wkr_in   = hold_wkr_ff;
            rsp_tag_in   = rd_data_ff;
            rsp_pos_in   = '0;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ready_mask_ff <= '0;
         reg_count_ff  <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         q_count_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ready_mask_ff <= ready_mask_in;
         reg_count_ff  <= reg_count_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         q_count_ff    <= q_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      hold_act_ff <= hold_act_in;
      hold_wkr_ff <= hold_wkr_in;
      rsp_act_ff  <= rsp_act_in;
      rsp_wkr_ff  <= rsp_wkr_in;
      rsp_tag_ff  <= rsp_tag_in;
      rsp_pos_ff  <= rsp_pos_in;
   end

   // Job RAM: write at tail, registered read at head
   always_ff @(posedge clock) begin
      if (mem_we) begin
         job_mem[tail_ff] <= req_tag;
      end
      rd_data_ff <= job_mem[head_ff];
   end

   // Response ports
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_act_ff;
   assign rsp_tdata  = {7'd0, rsp_pos_ff, rsp_tag_ff, rsp_wkr_ff};

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      q_count_ff <= QCT_BITS'(QUEUE_DEPTH))
      else $error("queued job count above queue depth");

   a_pool_or_queue: assert property (@(posedge clock) disable iff (reset)
      (ready_mask_ff != '0) |-> (q_count_ff == '0))
      else $error("ready worker while jobs are queued");

   a_pop_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP) |-> !rsp_valid_ff)
      else $error("output register busy during queue pop");

   a_pop_follows: assert property (@(posedge clock) disable iff (reset)
      (req_accept && pop_need) |=> (state_ff == ST_POP))
      else $error("pop not followed by read cycle");

   a_reg_bound: assert property (@(posedge clock) disable iff (reset)
      reg_count_ff <= CNT_BITS'(NUM_WORKERS))
      else $error("registered worker count above capacity");

endmodule
